[rtl/rfr_pkg.sv]
package rfr_pkg;

  // Default depth of the queue between the classifier and the record engine.
  localparam int unsigned QueueDepth = 2;

  // Line characters of the protocol.
  localparam logic [6:0] CH_READY  = 7'd2;
  localparam logic [6:0] CH_GOT_IT = 7'd6;
  localparam logic [6:0] CH_RESEND = 7'd7;
  localparam logic [6:0] CH_TAB    = 7'd9;
  localparam logic [6:0] CH_EOR    = 7'd10;
  localparam logic [6:0] CH_CR     = 7'd13;
  localparam logic [6:0] CH_RETRY  = 7'd21;
  localparam logic [6:0] CH_SPACE  = 7'd32;
  localparam logic [6:0] CH_DEL    = 7'd127;
  localparam logic [6:0] CH_ZERO   = 7'd48;
  localparam logic [6:0] CH_NINE   = 7'd57;

  // Checksum modulus and the number of line ends that close the session.
  localparam logic [7:0] CK_MOD     = 8'd99;
  localparam logic [7:0] CK_MOD_X2  = 8'd198;
  localparam logic [9:0] CK_MAX     = 10'd98;
  localparam logic [1:0] RUN_LIMIT  = 2'd3;

  // Widths of the packed stream words.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN1,
    PH_LEN2,
    PH_DATA,
    PH_CSUM,
    PH_DISCARD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_DATA,
    EV_ACCEPT,
    EV_REJECT,
    EV_RESEND,
    EV_TERM
  } event_t;

  // One classified line character, as queued for the record engine.
  typedef struct packed {
    logic [6:0] ch;
    logic       is_digit;
    logic       is_ctrl;
    logic       is_eor;
    logic       is_cr;
    logic       is_resend;
    logic       is_ready;
  } rx_class_t;

  // One result item.
  typedef struct packed {
    event_t     kind;
    logic [6:0] data_byte;
    logic [6:0] record_length;
    logic       reply_valid;
    logic [6:0] reply_char;
  } result_t;

endpackage

[rtl/record_frame_receiver.sv]
// Receiver for framed, checksummed records arriving one line character at a time.
// Input stream: in_tdata carries one received character; only its low 7 bits count.
// Output stream: one result transfer per input transfer, in order. out_tuser holds
// the event kind (none, tentative data byte, accepted, rejected, resend, terminated);
// out_tdata holds the data byte, the record length on accept and the reply character.
// A record is a ready character, a two-digit length, the data bytes and a decimal
// checksum closed by newline; the checksum is the byte sum mod 99.
// Throughput: one character per cycle while out_tready stays high; the record engine
// updates all its state together, so its loop sets the rate.
// A small queue sits between the classifier and the engine, and the result sits in an
// output register, so in_tready stays high while one result waits to be taken.
// When the receiver holds out_tready low, the queue fills and in_tready drops once it
// is full; nothing is lost. After three line ends in a row the block reports
// termination and from then on answers every character with an empty event.
// Reset (rst_n low, synchronous) empties the queue and output and returns the
// engine to waiting for a ready character with the last reply set to ready.
module record_frame_receiver #(
  parameter int unsigned QueueDepth = rfr_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rfr_pkg::InDataW-1:0]    in_tdata,   // [7:0] rx_char
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rfr_pkg::OutDataW-1:0]   out_tdata,  // [6:0] data_byte, [13:7] record_length,
                                                     // [14] reply_valid, [21:15] reply_char
  output logic [rfr_pkg::OutUserW-1:0]   out_tuser   // [2:0] event_kind
);

  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_not_empty;
  rfr_pkg::rx_class_t push_item;
  rfr_pkg::rx_class_t pop_item;
  rfr_pkg::result_t   result;

  rfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .rx_char   (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  rfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  rfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Pack the result fields from the lowest bit up.
  assign out_tdata = {2'b00, result.reply_char, result.reply_valid,
                      result.record_length, result.data_byte};
  assign out_tuser = result.kind;

endmodule

[rtl/rfr_front.sv]
module rfr_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            rx_char,
  input  logic                  q_full,
  output logic                  q_push,
  output rfr_pkg::rx_class_t    q_item
);

  logic [6:0] c;

  assign c = rx_char[6:0];

  // Accept a character whenever the queue has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify the masked character once; the engine uses these flags along with the character.
  always_comb begin
    q_item.ch        = c;
    q_item.is_digit  = (c >= rfr_pkg::CH_ZERO) && (c <= rfr_pkg::CH_NINE);
    q_item.is_ctrl   = !(((c >= rfr_pkg::CH_SPACE) && (c != rfr_pkg::CH_DEL)) ||
                         (c == rfr_pkg::CH_TAB));
    q_item.is_eor    = (c == rfr_pkg::CH_EOR);
    q_item.is_cr     = (c == rfr_pkg::CH_CR);
    q_item.is_resend = (c == rfr_pkg::CH_RESEND);
    q_item.is_ready  = (c == rfr_pkg::CH_READY);
  end

endmodule

[rtl/rfr_queue.sv]
module rfr_queue #(
  parameter int unsigned Depth = rfr_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfr_pkg::rx_class_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output rfr_pkg::rx_class_t pop_item
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(Depth);

  rfr_pkg::rx_class_t slot_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CntFull);
  assign not_empty = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/rfr_back.sv]
module rfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rfr_pkg::rx_class_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rfr_pkg::result_t   out_result
);

  rfr_pkg::phase_t  phase_r, phase_nxt;
  logic [6:0]       len_r, len_nxt;
  logic [6:0]       seen_r, seen_nxt;
  logic [6:0]       sum_r, sum_nxt;
  logic [6:0]       cks_r, cks_nxt;
  logic             too_big_r, too_big_nxt;
  logic [1:0]       run_r, run_nxt;
  logic [6:0]       last_reply_r, last_reply_nxt;
  logic             out_valid_r, out_valid_nxt;
  rfr_pkg::result_t res_r, res_nxt;

  // Take the next character when the output register is free or drains now.
  assign q_pop      = q_valid && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_result = res_r;

  // Record engine: one character per cycle while the output register is free or drains.
  always_comb begin
    logic [3:0] digit;
    logic [7:0] sum_wide;
    logic [9:0] cks_wide;
    logic [6:0] seen_inc;
    logic [6:0] len_sum;
    logic       fail;

    digit    = q_item.ch[3:0];
    sum_wide = {1'b0, sum_r} + {1'b0, q_item.ch};
    cks_wide = ({3'b000, cks_r} * 10'd10) + {6'b000000, digit};
    seen_inc = seen_r + 7'd1;
    len_sum  = len_r + {3'b000, digit};
    fail     = 1'b0;

    phase_nxt      = phase_r;
    len_nxt        = len_r;
    seen_nxt       = seen_r;
    sum_nxt        = sum_r;
    cks_nxt        = cks_r;
    too_big_nxt    = too_big_r;
    run_nxt        = run_r;
    last_reply_nxt = last_reply_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    res_nxt        = res_r;

    if (q_pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '{kind: rfr_pkg::EV_NONE, default: '0};

      if (phase_r != rfr_pkg::PH_DONE) begin
        // Count a run of line ends; any other character breaks it.
        if (q_item.is_eor || q_item.is_cr) begin
          run_nxt = (run_r == rfr_pkg::RUN_LIMIT) ? run_r : run_r + 2'd1;
        end else begin
          run_nxt = '0;
        end

        if (run_nxt == rfr_pkg::RUN_LIMIT) begin
          phase_nxt    = rfr_pkg::PH_DONE;
          res_nxt.kind = rfr_pkg::EV_TERM;
        end else if (q_item.is_resend) begin
          res_nxt.kind        = rfr_pkg::EV_RESEND;
          res_nxt.reply_valid = 1'b1;
          res_nxt.reply_char  = last_reply_r;
        end else begin
          case (phase_r)
            rfr_pkg::PH_WAIT: begin
              if (q_item.is_ready) begin
                phase_nxt = rfr_pkg::PH_LEN1;
              end
            end
            rfr_pkg::PH_LEN1: begin
              if (q_item.is_digit) begin
                len_nxt   = {3'b000, digit} * 7'd10;
                phase_nxt = rfr_pkg::PH_LEN2;
              end else if (!q_item.is_ready) begin
                fail = 1'b1;
              end
            end
            rfr_pkg::PH_LEN2: begin
              if (q_item.is_digit) begin
                len_nxt     = len_sum;
                seen_nxt    = '0;
                sum_nxt     = '0;
                cks_nxt     = '0;
                too_big_nxt = 1'b0;
                phase_nxt   = (len_sum != '0) ? rfr_pkg::PH_DATA : rfr_pkg::PH_CSUM;
              end else begin
                fail = 1'b1;
              end
            end
            rfr_pkg::PH_DATA: begin
              if (q_item.is_ctrl) begin
                fail = 1'b1;
              end else begin
                // Running sum mod 99; the raw sum stays below twice the modulus plus 29.
                if (sum_wide >= rfr_pkg::CK_MOD_X2) begin
                  sum_nxt = 7'(sum_wide - rfr_pkg::CK_MOD_X2);
                end else if (sum_wide >= rfr_pkg::CK_MOD) begin
                  sum_nxt = 7'(sum_wide - rfr_pkg::CK_MOD);
                end else begin
                  sum_nxt = sum_wide[6:0];
                end
                seen_nxt = seen_inc;
                if (seen_inc >= len_r) begin
                  phase_nxt = rfr_pkg::PH_CSUM;
                end
                res_nxt.kind      = rfr_pkg::EV_DATA;
                res_nxt.data_byte = q_item.ch;
              end
            end
            rfr_pkg::PH_CSUM: begin
              if (q_item.is_digit) begin
                if (!too_big_r) begin
                  if (cks_wide > rfr_pkg::CK_MAX) begin
                    too_big_nxt = 1'b1;
                  end else begin
                    cks_nxt = cks_wide[6:0];
                  end
                end
              end else if (!q_item.is_eor) begin
                fail = 1'b1;
              end else if (!too_big_r && (cks_r == sum_r)) begin
                last_reply_nxt        = rfr_pkg::CH_GOT_IT;
                phase_nxt             = rfr_pkg::PH_WAIT;
                res_nxt.kind          = rfr_pkg::EV_ACCEPT;
                res_nxt.record_length = len_r;
                res_nxt.reply_valid   = 1'b1;
                res_nxt.reply_char    = rfr_pkg::CH_GOT_IT;
              end else begin
                fail = 1'b1;
              end
            end
            rfr_pkg::PH_DISCARD: begin
              // Skip everything up to the end of the record.
              fail = q_item.is_eor;
            end
            default: begin
              res_nxt.kind = rfr_pkg::EV_NONE;
            end
          endcase

          // A framing error rejects at end of record, or starts discarding.
          if (fail) begin
            if (q_item.is_eor) begin
              last_reply_nxt      = rfr_pkg::CH_RETRY;
              phase_nxt           = rfr_pkg::PH_WAIT;
              res_nxt.kind        = rfr_pkg::EV_REJECT;
              res_nxt.reply_valid = 1'b1;
              res_nxt.reply_char  = rfr_pkg::CH_RETRY;
            end else begin
              phase_nxt = rfr_pkg::PH_DISCARD;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rfr_pkg::PH_WAIT;
      len_r        <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      cks_r        <= '0;
      too_big_r    <= 1'b0;
      run_r        <= '0;
      last_reply_r <= rfr_pkg::CH_READY;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      len_r        <= len_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
      cks_r        <= cks_nxt;
      too_big_r    <= too_big_nxt;
      run_r        <= run_nxt;
      last_reply_r <= last_reply_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

[rtl/rfr_checker.sv]
module rfr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [rfr_pkg::OutDataW-1:0] out_tdata,
  input logic [rfr_pkg::OutUserW-1:0] out_tuser
);

  // A stalled result transfer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A reply is flagged exactly for accept, reject and resend events.
  a_reply_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14] == ((out_tuser == rfr_pkg::EV_ACCEPT) ||
                                     (out_tuser == rfr_pkg::EV_REJECT) ||
                                     (out_tuser == rfr_pkg::EV_RESEND)))
    else $error("reply flag does not match event kind");

  // Accept replies with got-it, reject with retransmit.
  a_reply_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == rfr_pkg::EV_ACCEPT) || (out_tuser == rfr_pkg::EV_REJECT)) |->
      out_tdata[21:15] == ((out_tuser == rfr_pkg::EV_ACCEPT) ? rfr_pkg::CH_GOT_IT
                                                             : rfr_pkg::CH_RETRY))
    else $error("wrong reply character");

  // The data byte is carried only by data events, and then it is printable.
  a_data_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == rfr_pkg::EV_DATA) ?
                    ((out_tdata[6:0] >= rfr_pkg::CH_SPACE) || (out_tdata[6:0] == rfr_pkg::CH_TAB))
                    : (out_tdata[6:0] == 7'd0)))
    else $error("data byte field inconsistent with event kind");

  // The input side is never refused while both the input and the output side stay idle.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tvalid && !out_tvalid ##1 !in_tvalid && !out_tvalid |-> in_tready)
    else $error("input stalled while nothing is pending");

endmodule

bind record_frame_receiver rfr_checker u_rfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
